>>> sv/jesp_pkg.sv
// ----------------------------------------------------------------------------
// jesp_pkg
// Shared constants, register indexes and sequencer states of the junction
// entry speed planner.
// ----------------------------------------------------------------------------
package jesp_pkg;

   // axes that carry a direction component, and stored direction slots
   localparam int AXES      = 4;
   localparam int DIR_SLOTS = 4;
   localparam int DOT_TERMS = (AXES < DIR_SLOTS) ? AXES : DIR_SLOTS;
   localparam int DIR_IDX_W = $clog2(DIR_SLOTS);

   // configuration address width: four 32-bit registers
   localparam int ADDR_W = 4;

   // 0.9999 in signed Q4.30, and one in Q30
   localparam logic signed [33:0] COS_LIMIT  = 34'sd1073634449;
   localparam logic signed [33:0] Q30_ONE_S  = 34'sd1073741824;
   localparam logic [31:0]        Q30_ONE    = 32'h4000_0000;

   // register reset values
   localparam logic [31:0] JD_RESET  = 32'd3277;
   localparam logic        ZEN_RESET = 1'b0;
   localparam logic [31:0] ZJD_RESET = 32'd0;
   localparam logic [31:0] MIN_RESET = 32'd0;

   // last iteration index of each serial unit
   localparam logic [5:0] MUL_LAST  = 6'd31;
   localparam logic [5:0] DIV_LAST  = 6'd63;
   localparam logic [5:0] SQRT_LAST = 6'd31;
   localparam logic [5:0] DOT_LAST  = 6'(DOT_TERMS - 1);

   // register indexes
   typedef enum logic [1:0] {
      REG_JD  = 2'd0,
      REG_ZEN = 2'd1,
      REG_ZJD = 2'd2,
      REG_MIN = 2'd3
   } reg_index_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RATE_MUL,
      ST_RATE_DIV,
      ST_QMUL,
      ST_TMUL,
      ST_VSQRT,
      ST_DOT,
      ST_SSQRT,
      ST_RDIV,
      ST_MMUL,
      ST_MRMUL,
      ST_LSQRT,
      ST_FINISH
   } state_type;

endpackage

>>> sv/jesp_req_if.sv
// ----------------------------------------------------------------------------
// jesp_req_if
// Move channel: one planned move per transaction.
// ----------------------------------------------------------------------------
interface jesp_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] dir_x;
   logic signed [15:0] dir_y;
   logic signed [15:0] dir_z;
   logic signed [15:0] dir_extra;
   logic               has_direction;
   logic [31:0]        feed_speed;
   logic [31:0]        move_length;
   logic [31:0]        accel_limit;
   logic [30:0]        step_count;
   logic               primary_class;
   logic               vertical_only;
   logic               queue_empty;

   modport source (
      output valid, dir_x, dir_y, dir_z, dir_extra, has_direction, feed_speed,
             move_length, accel_limit, step_count, primary_class, vertical_only,
             queue_empty,
      input  ready
   );
   modport sink (
      input  valid, dir_x, dir_y, dir_z, dir_extra, has_direction, feed_speed,
             move_length, accel_limit, step_count, primary_class, vertical_only,
             queue_empty,
      output ready
   );
endinterface

>>> sv/jesp_rsp_if.sv
// ----------------------------------------------------------------------------
// jesp_rsp_if
// Result channel: speed limits of one move per transaction.
// ----------------------------------------------------------------------------
interface jesp_rsp_if;
   logic        valid;
   logic        ready;
   logic        skipped;
   logic [31:0] max_entry;
   logic [31:0] start_speed;
   logic [31:0] step_rate;
   logic        reaches_nominal;

   modport source (
      output valid, skipped, max_entry, start_speed, step_rate, reaches_nominal,
      input  ready
   );
   modport sink (
      input  valid, skipped, max_entry, start_speed, step_rate, reaches_nominal,
      output ready
   );
endinterface

>>> sv/junction_entry_speed_planner.sv
// ----------------------------------------------------------------------------
// junction_entry_speed_planner
// Cornering speed limit, entry speed and nominal step rate of planned moves.
// ----------------------------------------------------------------------------
// Usage
//   req_ch carries one move per transaction; rsp_ch returns exactly one result
//   per move. Registers are to be written over the APB-style port only while
//   idle; the block itself does not enforce it. All products but the direction
//   dot product, and all quotients and square roots, run on three bit-serial
//   units driven by one sequencer: a shift-add multiplier, a restoring
//   divider and a two-bits-per-cycle square root. A move with zero steps goes
//   straight to the result. Any other move runs the rate multiply and divide,
//   the two products of the deceleration bound and its square root (skipped
//   when the deceleration sum overflows 64 bits), then the direction test if
//   it runs; a full cornering calculation adds the half-angle square root, the
//   radius divide, two multiplies and a last square root. One move is worked
//   on at a time and the next one is taken in the idle cycle right after.
//   The result sits in an output register: the next move is accepted while
//   it waits, and the sequencer only holds in its last state if the receiver
//   still stalls the previous result when the next one is finished.
//   Reset (synchronous) restores the register defaults, clears the previous
//   move's direction, speed, acceleration and class, and empties rsp_ch.
// ----------------------------------------------------------------------------
module junction_entry_speed_planner (
   input  logic                         clock,
   input  logic                         reset,
   jesp_req_if.sink                     req_ch,
   jesp_rsp_if.source                   rsp_ch,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [jesp_pkg::ADDR_W-1:0]  paddr,
   input  logic [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);
   import jesp_pkg::*;

   // control state
   state_type   state_ff, state_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // configuration registers
   logic [31:0] jd_ff, zjd_ff, min_ff;
   logic        zen_ff;

   // previous move
   logic signed [15:0] last_dir_ff [DIR_SLOTS];
   logic signed [15:0] last_dir_in [DIR_SLOTS];
   logic [31:0] last_speed_ff, last_speed_in;
   logic [31:0] last_accel_ff, last_accel_in;
   logic        last_class_ff, last_class_in;

   // latched move
   logic signed [15:0] dir_ff [DIR_SLOTS];
   logic signed [15:0] dir_in [DIR_SLOTS];
   logic        has_dir_ff, has_dir_in;
   logic [31:0] feed_ff, feed_in;
   logic [31:0] len_ff, len_in;
   logic [31:0] acc_ff, acc_in;
   logic        cls_ff, cls_in;
   logic        vert_ff, vert_in;
   logic        qempty_ff, qempty_in;
   logic        skip_ff, skip_in;

   // intermediate results
   logic [31:0] rate_ff, rate_in;
   logic [63:0] q_ff, q_in;
   logic [31:0] vallow_ff, vallow_in;
   logic [31:0] vmax_ff, vmax_in;
   logic [31:0] r_ff, r_in;
   logic signed [33:0] dot_ff, dot_in;

   // serial units
   logic [47:0] mul_a_ff, mul_a_in;
   logic [79:0] mul_p_ff, mul_p_in;
   logic [63:0] div_n_ff, div_n_in;
   logic [31:0] div_r_ff, div_r_in;
   logic [31:0] div_d_ff, div_d_in;
   logic [63:0] sq_x_ff, sq_x_in;
   logic [33:0] sq_rem_ff, sq_rem_in;
   logic [31:0] sq_root_ff, sq_root_in;

   // output register
   logic        o_skip_ff, o_skip_in;
   logic [31:0] o_max_ff, o_max_in;
   logic [31:0] o_entry_ff, o_entry_in;
   logic [31:0] o_rate_ff, o_rate_in;
   logic        o_reach_ff, o_reach_in;

   // unit step values
   logic [48:0] mul_sum;
   logic [79:0] mul_step;
   logic [32:0] div_sh, div_diff;
   logic        div_ge;
   logic [31:0] div_rem_step;
   logic [63:0] div_quo_step;
   logic [35:0] sq_sh, sq_trial, sq_diff;
   logic        sq_ge;
   logic [33:0] sq_rem_step;
   logic [31:0] sq_root_step;

   // move-level terms
   logic [DIR_IDX_W-1:0] dot_idx;
   logic signed [31:0]   dot_prod;
   logic signed [33:0]   dot_step, cos_step, one_minus_cos;
   logic [31:0] nominal, dev, amin, s_root;
   logic        corner_ok, accept, cfg_write, out_free;
   logic [65:0] v_sum;
   reg_index_type cfg_idx;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept    = req_ch.valid && req_ch.ready;
   assign cfg_write = psel && penable && pwrite && pready;
   assign cfg_idx   = reg_index_type'(paddr[ADDR_W-1:2]);
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;

   // register read back
   assign pready = 1'b1;
   always_comb begin
      case (cfg_idx)
         REG_JD:  prdata = jd_ff;
         REG_ZEN: prdata = {31'd0, zen_ff};
         REG_ZJD: prdata = zjd_ff;
         REG_MIN: prdata = min_ff;
         default: prdata = 32'd0;
      endcase
   end

   // shift-add multiplier step
   assign mul_sum  = {1'b0, mul_p_ff[79:32]} + (mul_p_ff[0] ? {1'b0, mul_a_ff} : 49'd0);
   assign mul_step = {mul_sum, mul_p_ff[31:1]};

   // restoring divider step
   assign div_sh       = {div_r_ff, div_n_ff[63]};
   assign div_diff     = div_sh - {1'b0, div_d_ff};
   assign div_ge       = div_sh >= {1'b0, div_d_ff};
   assign div_rem_step = div_ge ? div_diff[31:0] : div_sh[31:0];
   assign div_quo_step = {div_n_ff[62:0], div_ge};

   // square root step, two radicand bits per cycle
   assign sq_sh        = {sq_rem_ff, sq_x_ff[63:62]};
   assign sq_trial     = {2'b00, sq_root_ff, 2'b01};
   assign sq_diff      = sq_sh - sq_trial;
   assign sq_ge        = sq_sh >= sq_trial;
   assign sq_rem_step  = sq_ge ? sq_diff[33:0] : sq_sh[33:0];
   assign sq_root_step = {sq_root_ff[30:0], sq_ge};

   // direction dot product term
   assign dot_idx       = cnt_ff[DIR_IDX_W-1:0];
   assign dot_prod      = last_dir_ff[dot_idx] * dir_ff[dot_idx];
   assign dot_step      = dot_ff + {{2{dot_prod[31]}}, dot_prod};
   assign cos_step      = -dot_step;
   assign one_minus_cos = Q30_ONE_S - cos_step;

   // move terms
   assign nominal   = (len_ff != 32'd0) ? feed_ff : 32'd0;
   assign dev       = (vert_ff && zen_ff) ? zjd_ff : jd_ff;
   assign amin      = (last_accel_ff < acc_ff) ? last_accel_ff : acc_ff;
   assign corner_ok = has_dir_ff && !qempty_ff && (dev != 32'd0) &&
                      (last_class_ff == cls_ff) && (last_speed_ff != 32'd0);
   assign v_sum     = {2'b00, q_ff} + {1'b0, mul_step[63:0], 1'b0};
   assign s_root    = sq_root_step;

   // sequencer next state and datapath
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff - 6'd1;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      last_dir_in   = last_dir_ff;
      last_speed_in = last_speed_ff;
      last_accel_in = last_accel_ff;
      last_class_in = last_class_ff;
      dir_in        = dir_ff;
      has_dir_in    = has_dir_ff;
      feed_in       = feed_ff;
      len_in        = len_ff;
      acc_in        = acc_ff;
      cls_in        = cls_ff;
      vert_in       = vert_ff;
      qempty_in     = qempty_ff;
      skip_in       = skip_ff;
      rate_in       = rate_ff;
      q_in          = q_ff;
      vallow_in     = vallow_ff;
      vmax_in       = vmax_ff;
      r_in          = r_ff;
      dot_in        = dot_ff;
      mul_a_in      = mul_a_ff;
      mul_p_in      = mul_step;
      div_n_in      = div_quo_step;
      div_r_in      = div_rem_step;
      div_d_in      = div_d_ff;
      sq_x_in       = {sq_x_ff[61:0], 2'b00};
      sq_rem_in     = sq_rem_step;
      sq_root_in    = sq_root_step;
      o_skip_in     = o_skip_ff;
      o_max_in      = o_max_ff;
      o_entry_in    = o_entry_ff;
      o_rate_in     = o_rate_ff;
      o_reach_in    = o_reach_ff;

      case (state_ff)
         ST_IDLE: begin
            dir_in[0]  = req_ch.dir_x;
            dir_in[1]  = req_ch.dir_y;
            dir_in[2]  = req_ch.dir_z;
            dir_in[3]  = req_ch.dir_extra;
            has_dir_in = req_ch.has_direction;
            feed_in    = req_ch.feed_speed;
            len_in     = req_ch.move_length;
            acc_in     = req_ch.accel_limit;
            cls_in     = req_ch.primary_class;
            vert_in    = req_ch.vertical_only;
            qempty_in  = req_ch.queue_empty;
            skip_in    = (req_ch.step_count == 31'd0);
            mul_a_in   = {16'd0, req_ch.feed_speed};
            mul_p_in   = {48'd0, 1'b0, req_ch.step_count};
            cnt_in     = MUL_LAST;
            if (accept) begin
               state_in = (req_ch.step_count == 31'd0) ? ST_FINISH : ST_RATE_MUL;
            end
         end
         // steps times feed
         ST_RATE_MUL: begin
            if (cnt_ff == 6'd0) begin
               div_n_in = mul_step[63:0];
               div_r_in = 32'd0;
               div_d_in = len_ff;
               cnt_in   = DIV_LAST;
               state_in = ST_RATE_DIV;
            end
         end
         // divide by length, saturate
         ST_RATE_DIV: begin
            if (cnt_ff == 6'd0) begin
               if (len_ff == 32'd0) begin
                  rate_in = 32'd0;
               end else if (div_quo_step[63:32] != 32'd0) begin
                  rate_in = 32'hFFFF_FFFF;
               end else begin
                  rate_in = div_quo_step[31:0];
               end
               mul_a_in = {16'd0, min_ff};
               mul_p_in = {48'd0, min_ff};
               cnt_in   = MUL_LAST;
               state_in = ST_QMUL;
            end
         end
         // minimum speed squared
         ST_QMUL: begin
            if (cnt_ff == 6'd0) begin
               q_in     = mul_step[63:0];
               mul_a_in = {16'd0, acc_ff};
               mul_p_in = {48'd0, len_ff};
               cnt_in   = MUL_LAST;
               state_in = ST_TMUL;
            end
         end
         // accel times length, then deceleration bound
         ST_TMUL: begin
            if (cnt_ff == 6'd0) begin
               sq_x_in    = v_sum[63:0];
               sq_rem_in  = 34'd0;
               sq_root_in = 32'd0;
               cnt_in     = SQRT_LAST;
               if (v_sum[65:64] != 2'd0) begin
                  vallow_in = 32'hFFFF_FFFF;
                  dot_in    = 34'sd0;
                  cnt_in    = DOT_LAST;
                  vmax_in   = min_ff;
                  state_in  = corner_ok ? ST_DOT : ST_FINISH;
               end else begin
                  state_in = ST_VSQRT;
               end
            end
         end
         ST_VSQRT: begin
            if (cnt_ff == 6'd0) begin
               vallow_in = sq_root_step;
               dot_in    = 34'sd0;
               cnt_in    = DOT_LAST;
               vmax_in   = min_ff;
               state_in  = corner_ok ? ST_DOT : ST_FINISH;
            end
         end
         // dot product of old and new directions
         ST_DOT: begin
            dot_in = dot_step;
            if (cnt_ff == 6'd0) begin
               sq_x_in    = {3'd0, one_minus_cos[31:1], 30'd0};
               sq_rem_in  = 34'd0;
               sq_root_in = 32'd0;
               cnt_in     = SQRT_LAST;
               if (cos_step > COS_LIMIT) begin
                  vmax_in  = min_ff;
                  state_in = ST_FINISH;
               end else begin
                  vmax_in  = (last_speed_ff < nominal) ? last_speed_ff : nominal;
                  state_in = (cos_step < -COS_LIMIT) ? ST_FINISH : ST_SSQRT;
               end
            end
         end
         // sine of half angle
         ST_SSQRT: begin
            if (cnt_ff == 6'd0) begin
               div_n_in = {16'd0, s_root, 16'd0};
               div_r_in = 32'd0;
               div_d_in = Q30_ONE - s_root;
               cnt_in   = DIV_LAST;
               state_in = ST_RDIV;
            end
         end
         // corner radius factor
         ST_RDIV: begin
            if (cnt_ff == 6'd0) begin
               r_in     = div_quo_step[31:0];
               mul_a_in = {16'd0, amin};
               mul_p_in = {48'd0, dev};
               cnt_in   = MUL_LAST;
               state_in = ST_MMUL;
            end
         end
         // acceleration times deviation
         ST_MMUL: begin
            if (cnt_ff == 6'd0) begin
               mul_a_in = mul_step[63:16];
               mul_p_in = {48'd0, r_ff};
               cnt_in   = MUL_LAST;
               state_in = ST_MRMUL;
            end
         end
         // m times r, unbounded when over 64 bits
         ST_MRMUL: begin
            if (cnt_ff == 6'd0) begin
               sq_x_in    = mul_step[63:0];
               sq_rem_in  = 34'd0;
               sq_root_in = 32'd0;
               cnt_in     = SQRT_LAST;
               state_in   = (mul_step[79:64] != 16'd0) ? ST_FINISH : ST_LSQRT;
            end
         end
         ST_LSQRT: begin
            if (cnt_ff == 6'd0) begin
               if (sq_root_step < vmax_ff) begin
                  vmax_in = sq_root_step;
               end
               state_in = ST_FINISH;
            end
         end
         // load result register and, for a move with steps, update previous move
         ST_FINISH: begin
            cnt_in = cnt_ff;
            if (out_free) begin
               rsp_valid_in = 1'b1;
               o_skip_in    = skip_ff;
               if (skip_ff) begin
                  o_max_in   = 32'd0;
                  o_entry_in = 32'd0;
                  o_rate_in  = 32'd0;
                  o_reach_in = 1'b0;
               end else begin
                  o_max_in   = vmax_ff;
                  o_entry_in = (vmax_ff < vallow_ff) ? vmax_ff : vallow_ff;
                  o_rate_in  = rate_ff;
                  o_reach_in = (nominal <= vallow_ff);
                  for (int i = 0; i < DIR_SLOTS; i++) begin
                     last_dir_in[i] = has_dir_ff ? dir_ff[i] : 16'sd0;
                  end
                  last_speed_in = nominal;
                  last_accel_in = acc_ff;
                  last_class_in = cls_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= 6'd0;
         rsp_valid_ff  <= 1'b0;
         jd_ff         <= JD_RESET;
         zen_ff        <= ZEN_RESET;
         zjd_ff        <= ZJD_RESET;
         min_ff        <= MIN_RESET;
         for (int i = 0; i < DIR_SLOTS; i++) begin
            last_dir_ff[i] <= 16'sd0;
         end
         last_speed_ff <= 32'd0;
         last_accel_ff <= 32'd0;
         last_class_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
         last_dir_ff   <= last_dir_in;
         last_speed_ff <= last_speed_in;
         last_accel_ff <= last_accel_in;
         last_class_ff <= last_class_in;
         if (cfg_write) begin
            case (cfg_idx)
               REG_JD:  jd_ff  <= pwdata;
               REG_ZEN: zen_ff <= pwdata[0];
               REG_ZJD: zjd_ff <= pwdata;
               REG_MIN: min_ff <= pwdata;
               default: ;
            endcase
         end
      end
   end

   // payload and serial unit registers
   always_ff @(posedge clock) begin
      dir_ff     <= dir_in;
      has_dir_ff <= has_dir_in;
      feed_ff    <= feed_in;
      len_ff     <= len_in;
      acc_ff     <= acc_in;
      cls_ff     <= cls_in;
      vert_ff    <= vert_in;
      qempty_ff  <= qempty_in;
      skip_ff    <= skip_in;
      rate_ff    <= rate_in;
      q_ff       <= q_in;
      vallow_ff  <= vallow_in;
      vmax_ff    <= vmax_in;
      r_ff       <= r_in;
      dot_ff     <= dot_in;
      mul_a_ff   <= mul_a_in;
      mul_p_ff   <= mul_p_in;
      div_n_ff   <= div_n_in;
      div_r_ff   <= div_r_in;
      div_d_ff   <= div_d_in;
      sq_x_ff    <= sq_x_in;
      sq_rem_ff  <= sq_rem_in;
      sq_root_ff <= sq_root_in;
      o_skip_ff  <= o_skip_in;
      o_max_ff   <= o_max_in;
      o_entry_ff <= o_entry_in;
      o_rate_ff  <= o_rate_in;
      o_reach_ff <= o_reach_in;
   end

   // result channel
   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.skipped         = o_skip_ff;
   assign rsp_ch.max_entry       = o_max_ff;
   assign rsp_ch.start_speed     = o_entry_ff;
   assign rsp_ch.step_rate       = o_rate_ff;
   assign rsp_ch.reaches_nominal = o_reach_ff;

endmodule

>>> sv/jesp_checker.sv
// ----------------------------------------------------------------------------
// jesp_checker
// Port-level checks of the junction entry speed planner, bound to the top.
// ----------------------------------------------------------------------------
module jesp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        skipped,
   input logic [31:0] max_entry,
   input logic [31:0] start_speed,
   input logic [31:0] step_rate,
   input logic        reaches_nominal,
   input logic        pready
);
   import jesp_pkg::*;

   // a stalled result transaction stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // dropped move reports zero fields
   a_skip_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && skipped |-> max_entry == 32'd0 && start_speed == 32'd0 &&
                               step_rate == 32'd0 && !reaches_nominal)
      else $error("skipped move with nonzero fields");

   // entry speed never above junction limit
   a_entry_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> start_speed <= max_entry)
      else $error("entry speed above junction limit");

   // register port never waits
   a_pready: assert property (@(posedge clock) disable iff (reset)
      pready)
      else $error("pready low");

endmodule

bind junction_entry_speed_planner jesp_checker u_jesp_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .skipped         (rsp_ch.skipped),
   .max_entry       (rsp_ch.max_entry),
   .start_speed     (rsp_ch.start_speed),
   .step_rate       (rsp_ch.step_rate),
   .reaches_nominal (rsp_ch.reaches_nominal),
   .pready          (pready)
);
